// ===== hw/rtl/vnorm_pkg.sv =====
// Shared types, constants and helpers for the vector norm engine.
// No dependencies; every other file imports this package.
`default_nettype none

package vnorm_pkg;

  // Fixed field widths of the channels and the accumulator
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 48;
  localparam int RESULT_W  = 32;
  localparam int MODE_W    = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ITEMS   = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  // norm_mode codes; the unused code behaves as L2
  localparam logic [MODE_W-1:0] MODE_L2  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L1  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // Register word index
  localparam logic [APB_AW-3:0] REG_NORM_MODE = 1'b0;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,  // a + b, clamped to ACC_W bits
    ALU_MAX = 2'd1,  // larger of a and b
    ALU_SUB = 2'd2   // a - b - c, ge set when no borrow
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] y;
    logic             ge;
  } alu_rsp_t;

  // Clamp an accumulator-wide value to the result width
  function automatic logic [RESULT_W-1:0] sat_result(input logic [ACC_W-1:0] v);
    if (|v[ACC_W-1:RESULT_W]) begin
      return {RESULT_W{1'b1}};
    end
    return v[RESULT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vnorm_if.sv =====
// Valid/ready channel interfaces for the sample and result streams.
// Depends on vnorm_pkg for the field widths.
`default_nettype none

interface vnorm_in_if
  import vnorm_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface vnorm_out_if
  import vnorm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] norm_value;
  logic                saturated;

  modport source (output valid, norm_value, saturated, input ready);
  modport sink   (input valid, norm_value, saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vnorm_alu.sv =====
// Shared arithmetic unit: clamped add, max compare, and the
// trial subtract of the square-root loop. Depends on vnorm_pkg.
`default_nettype none

module vnorm_alu
  import vnorm_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ACC_W:0]   sum;
  logic [ACC_W+1:0] diff;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign diff = {2'b00, req.a} - {2'b00, req.b} - {2'b00, req.c};

  // Operation select
  always_comb begin
    rsp = '0;
    unique case (req.op)
      ALU_ADD: begin
        rsp.y  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        rsp.ge = 1'b1;
      end
      ALU_MAX: begin
        rsp.ge = (req.b > req.a);
        rsp.y  = rsp.ge ? req.b : req.a;
      end
      ALU_SUB: begin
        rsp.y  = diff[ACC_W-1:0];
        rsp.ge = ~diff[ACC_W+1];
      end
      default: begin
        rsp.y  = req.a;
        rsp.ge = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vnorm_apb.sv =====
// APB-style configuration register file holding norm_mode.
// Depends on vnorm_pkg.
`default_nettype none

module vnorm_apb
  import vnorm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [MODE_W-1:0] norm_mode
);

  logic [APB_AW-3:0] word_idx;
  logic              wr_en;

  assign word_idx = paddr[APB_AW-1:2];
  assign wr_en    = psel & penable & pwrite;
  assign pready   = 1'b1;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode <= MODE_L2;
    end else if (wr_en && word_idx == REG_NORM_MODE) begin
      norm_mode <= pwdata[MODE_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (word_idx)
      REG_NORM_MODE: prdata = APB_DW'(norm_mode);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vector_norm_l1_l2_max_top.sv =====
// Vector norm engine top level: sequencer, accumulator and result register.
// Depends on vnorm_pkg, vnorm_if, vnorm_alu and vnorm_apb.
`default_nettype none

// Streams a vector one signed sample per request, the final one marked by
// last, and returns one result on the last request: the L1 sum of
// magnitudes, the maximum magnitude, or the floor of the square root of the
// sum of squares (mode 0 and the unused code 3). One add/compare/subtract
// unit does the sums, compares and root trials under a small sequencer, so
// the input is busy while a request is worked on: each sample goes through
// S_SQ and S_ACC, and on the last sample in L2 mode the bit-by-bit root
// follows (one root bit per cycle through the shared unit); the result is
// loaded once the output register is free, and it can wait there while the
// next vector starts. Samples past MAX_ITEMS are dropped and flag the
// result as saturated. Only the low SAMPLE_BITS bits of a sample count.
module vector_norm_l1_l2_max_top
  import vnorm_pkg::*;
#(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  vnorm_in_if.sink               in_ch,
  vnorm_out_if.source            out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam logic [ACC_W-1:0] ROOT_BIT0 = ACC_W'(1) << (ACC_W - 2);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_ACC  = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [MODE_W-1:0]      norm_mode;
  logic [MODE_W-1:0]      mode_r;
  logic                   last_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SAMPLE_BITS-1:0] mag_in;
  logic [ACC_W-1:0]       term;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       res;
  logic [ACC_W-1:0]       root_bit;
  logic [CNT_W-1:0]       item_count;
  logic                   overflow_flag;
  logic                   is_l1;
  logic                   is_max;
  logic                   accept;
  logic                   out_free;
  logic                   out_valid;
  logic [RESULT_W-1:0]    norm_value;
  logic                   saturated;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  // Configuration port
  vnorm_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .norm_mode (norm_mode)
  );

  // Shared arithmetic unit
  vnorm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign is_l1  = (mode_r == MODE_L1);
  assign is_max = (mode_r == MODE_MAX);

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid & in_ch.ready;
  assign out_free    = ~out_valid | out_ch.ready;

  // Magnitude of the low SAMPLE_BITS bits; the most negative code maps to
  // 2^(SAMPLE_BITS-1), which still fits unsigned
  assign mag_in = in_ch.sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - in_ch.sample[SAMPLE_BITS-1:0])
                                              : in_ch.sample[SAMPLE_BITS-1:0];

  // ALU operand steering
  always_comb begin
    alu_req   = '0;
    alu_req.a = acc;
    alu_req.b = term;
    alu_req.c = '0;
    if (state == S_ROOT) begin
      alu_req.op = ALU_SUB;
      alu_req.b  = res;
      alu_req.c  = root_bit;
    end else if (is_max) begin
      alu_req.op = ALU_MAX;
    end else begin
      alu_req.op = ALU_ADD;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SQ;
      S_SQ:   state_next = S_ACC;
      S_ACC: begin
        if (!last_r)                   state_next = S_IDLE;
        else if (is_l1 || is_max)      state_next = S_DONE;
        else                           state_next = S_ROOT;
      end
      S_ROOT: if (root_bit[0])         state_next = S_DONE;
      S_DONE: if (out_free)            state_next = S_IDLE;
      default:                         state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and term (square or magnitude)
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r  <= mag_in;
      last_r <= in_ch.last;
      mode_r <= norm_mode;
    end
    if (state == S_SQ) begin
      if (is_l1 || is_max) begin
        term <= ACC_W'(mag_r);
      end else begin
        term <= ACC_W'(SQ_W'(mag_r) * SQ_W'(mag_r));
      end
    end
  end

  // Accumulator, count, overflow flag and root registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      item_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (item_count >= CNT_W'(MAX_ITEMS)) begin
            overflow_flag <= 1'b1;
          end else begin
            acc        <= alu_rsp.y;
            item_count <= item_count + CNT_W'(1);
          end
        end
        S_ROOT: begin
          if (alu_rsp.ge) begin
            acc <= alu_rsp.y;
          end
        end
        S_DONE: begin
          if (out_free) begin
            acc           <= '0;
            item_count    <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Root iteration: one result bit per cycle
  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      res      <= '0;
      root_bit <= ROOT_BIT0;
    end else if (state == S_ROOT) begin
      res      <= alu_rsp.ge ? ((res >> 1) + root_bit) : (res >> 1);
      root_bit <= root_bit >> 2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      norm_value <= sat_result((is_l1 || is_max) ? acc : res);
      saturated  <= overflow_flag;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.norm_value = norm_value;
  assign out_ch.saturated  = saturated;

endmodule

`default_nettype wire
